// File: src/tmr_pkg.sv
package tmr_pkg;

	localparam int STEP_LIMIT = 170;
	localparam int TAPE_DEPTH = 170;
	localparam int WORD_BITS = 64;
	localparam int TAPE_WORDS = (TAPE_DEPTH + WORD_BITS - 1) / WORD_BITS;
	localparam int TAPE_BITS = TAPE_WORDS * WORD_BITS;
	localparam int HEAD_W = $clog2(TAPE_DEPTH + 1);
	localparam int STEP_W = ($clog2(STEP_LIMIT + 1) > 8) ? $clog2(STEP_LIMIT + 1) : 8;
	localparam int NIB_W = 4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_EMIT
	} tmr_state_t;

	// control broadcast from the sequencer to every tape cell
	typedef struct packed {
		logic clear;
		logic step;
		logic move_left;
		logic wr_sym;
	} tmr_tape_ctl_t;

endpackage

// File: src/tmr_cell.sv
module tmr_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tmr_pkg::tmr_tape_ctl_t ctl,
	input  logic                   init_head,
	input  logic                   head_from_left,
	input  logic                   head_from_right,
	output logic                   head,
	output logic                   sym
);
	import tmr_pkg::*;

	logic head_q;
	logic sym_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			sym_q <= 1'b0;
		end else if (ctl.clear) begin
			head_q <= init_head;
			sym_q <= 1'b0;
		end else if (ctl.step) begin
			if (head_q) begin
				sym_q <= ctl.wr_sym;
			end
			// pass the head token to the neighbor on the side it moves to
			head_q <= ctl.move_left ? head_from_right : head_from_left;
		end
	end

	assign head = head_q;
	assign sym = sym_q;

endmodule

// File: src/tmr_tape.sv
module tmr_tape (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tmr_pkg::tmr_tape_ctl_t            ctl,
	output logic                              rd_sym,
	output logic [tmr_pkg::TAPE_DEPTH-1:0]    head_vec,
	output logic [tmr_pkg::TAPE_DEPTH-1:0]    sym_vec
);
	import tmr_pkg::*;

	genvar i;
	generate
		for (i = 0; i < TAPE_DEPTH; i++) begin : g_cell
			logic from_left;
			logic from_right;

			if (i == 0) begin : g_first
				assign from_left = 1'b0;
			end else begin : g_mid_l
				assign from_left = head_vec[i-1];
			end
			if (i == TAPE_DEPTH - 1) begin : g_end
				assign from_right = 1'b0;
			end else begin : g_mid_r
				assign from_right = head_vec[i+1];
			end

			tmr_cell u_cell (
				.clk             (clk),
				.arst_n          (arst_n),
				.ctl             (ctl),
				.init_head       ((i == 0) ? 1'b1 : 1'b0),
				.head_from_left  (from_left),
				.head_from_right (from_right),
				.head            (head_vec[i]),
				.sym             (sym_vec[i])
			);
		end
	endgenerate

	// token is one-hot, so this picks the symbol under the head
	assign rd_sym = |(head_vec & sym_vec);

endmodule

// File: src/turing_machine_runner.sv
// Run: the machine takes one step per cycle (at most 170 steps) from the start transfer,
// then shows one result per tape word, 1 or 2 (a halting run never passes cell 84);
// busy stays high until the last result has been shown.
// A new machine is accepted only in idle, after the last result of the one before; the
// head token walks one step per cycle along the tape cell chain.
// Reset: arst_n clears the sequencer to idle and empties the tape; results are never stalled.
module turing_machine_runner (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] machine_number,
	output logic        result_valid,
	output logic        halted,
	output logic [7:0]  step_count,
	output logic [7:0]  rightmost_cell,
	output logic [1:0]  word_index,
	output logic [63:0] tape_word,
	output logic        last
);
	import tmr_pkg::*;

	tmr_state_t              state_q;
	tmr_state_t              state_nxt;
	logic [31:0]             mnum_q;
	logic [1:0]              mstate_q;
	logic [HEAD_W-1:0]       head_q;
	logic [HEAD_W-1:0]       right_q;
	logic [STEP_W-1:0]       steps_q;
	logic                    halted_q;
	logic [1:0]              widx_q;

	tmr_tape_ctl_t           tape_ctl;
	logic                    rd_sym;
	logic [TAPE_DEPTH-1:0]   head_vec;
	logic [TAPE_DEPTH-1:0]   sym_vec;
	logic [TAPE_BITS-1:0]    tape_flat;

	logic                    accept;
	logic [2:0]              entry;
	logic [NIB_W-1:0]        nib;
	logic                    mv_left;
	logic [STEP_W-1:0]       steps_inc;
	logic [HEAD_W-1:0]       head_inc;
	logic                    hit_halt;
	logic                    hit_limit;
	logic                    hit_end;
	logic [1:0]              last_idx;
	logic                    last_word;

	// The tape: a row of cells, each with its symbol and a one-hot head token
	tmr_tape u_tape (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (tape_ctl),
		.rd_sym   (rd_sym),
		.head_vec (head_vec),
		.sym_vec  (sym_vec)
	);

	assign accept = start && (state_q == ST_IDLE);

	// Look up the transition for (state, symbol under head)
	assign entry = {mstate_q, rd_sym};
	assign nib = mnum_q[{entry, 2'b00} +: NIB_W];
	assign mv_left = nib[0];
	assign steps_inc = steps_q + STEP_W'(1);
	assign head_inc = head_q + HEAD_W'(1);

	// Ways a step ends the run: fall off the left end, hit the step limit, run off the tape
	assign hit_halt = mv_left && (head_q == '0);
	assign hit_limit = (steps_inc == STEP_W'(STEP_LIMIT));
	assign hit_end = !mv_left && (head_q == HEAD_W'(TAPE_DEPTH - 1));

	// Last word: index of the word holding the rightmost cell
	assign last_idx = 2'(right_q / HEAD_W'(WORD_BITS));
	assign last_word = !halted_q || (widx_q == last_idx);

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (hit_halt || hit_limit || hit_end) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (last_word) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		busy = 1'b1;
		result_valid = 1'b0;
		tape_ctl = '0;
		tape_ctl.move_left = mv_left;
		tape_ctl.wr_sym = nib[1];
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				tape_ctl.clear = start;
			end
			ST_RUN: begin
				tape_ctl.step = 1'b1;
			end
			ST_EMIT: begin
				result_valid = 1'b1;
			end
			default: busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Run registers: clear on a start transfer, advance once per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mnum_q <= '0;
			mstate_q <= '0;
			head_q <= '0;
			right_q <= '0;
			steps_q <= '0;
			halted_q <= 1'b0;
			widx_q <= '0;
		end else if (accept) begin
			mnum_q <= machine_number;
			mstate_q <= '0;
			head_q <= '0;
			right_q <= '0;
			steps_q <= '0;
			halted_q <= 1'b0;
			widx_q <= '0;
		end else if (state_q == ST_RUN) begin
			steps_q <= steps_inc;
			mstate_q <= nib[3:2];
			if (hit_halt) begin
				halted_q <= 1'b1;
			end else if (mv_left) begin
				head_q <= head_q - HEAD_W'(1);
			end else begin
				head_q <= head_inc;
				if (head_inc > right_q) begin
					right_q <= head_inc;
				end
			end
		end else if (state_q == ST_EMIT) begin
			// advance to the next tape word
			widx_q <= widx_q + 2'd1;
		end
	end

	// Cells past the rightmost one were never written and read as zero
	assign tape_flat = {{(TAPE_BITS - TAPE_DEPTH){1'b0}}, sym_vec};

	always_comb begin
		tape_word = '0;
		if (halted_q) begin
			case (widx_q)
				2'd0: tape_word = tape_flat[0 +: WORD_BITS];
				2'd1: tape_word = tape_flat[WORD_BITS +: WORD_BITS];
				2'd2: tape_word = tape_flat[2*WORD_BITS +: WORD_BITS];
				default: tape_word = '0;
			endcase
		end
	end

	assign halted = halted_q;
	assign step_count = steps_q[7:0];
	assign rightmost_cell = right_q[7:0];
	assign word_index = widx_q;
	assign last = last_word;

	// Results only come while the block is busy
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result shown while idle");

	// After the final result the block is free for the next machine
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last) |=> !busy && !result_valid)
		else $error("block still busy after last result");

	// Exactly one head token while a machine is stepping
	a_head_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> $onehot(head_vec))
		else $error("head token lost or duplicated");

	// Step count never passes the limit
	a_step_limit: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= STEP_W'(STEP_LIMIT))
		else $error("step counter past limit");

endmodule
